[design/est_pkg.sv]
`default_nettype none
package est_pkg;

	localparam int OP_W     = 2;
	localparam int FLOOR_W  = 6;
	localparam int DIR_W    = 2;
	localparam int TARGET_W = 6;
	localparam int COUNT_W  = 5;

	typedef logic [OP_W-1:0]     op_t;
	typedef logic [FLOOR_W-1:0]  floor_t;
	typedef logic [DIR_W-1:0]    dir_t;
	typedef logic [TARGET_W-1:0] target_t;
	typedef logic [COUNT_W-1:0]  count_t;

	localparam op_t OP_ADD    = 2'd0;
	localparam op_t OP_DELETE = 2'd1;
	localparam op_t OP_SEARCH = 2'd2;
	localparam op_t OP_TARGET = 2'd3;

	localparam dir_t DIR_IDLE = 2'd0;
	localparam dir_t DIR_UP   = 2'd1;
	localparam dir_t DIR_DOWN = 2'd2;

endpackage
`default_nettype wire

[design/est_req_if.sv]
`default_nettype none
interface est_req_if import est_pkg::*; ();
	logic    valid;
	logic    ready;
	op_t     op;
	floor_t  floor;
	dir_t    direction;
	target_t current_target;

	modport source (output valid, output op, output floor, output direction,
		output current_target, input ready);
	modport sink (input valid, input op, input floor, input direction,
		input current_target, output ready);
endinterface
`default_nettype wire

[design/est_rsp_if.sv]
`default_nettype none
interface est_rsp_if import est_pkg::*; ();
	logic    valid;
	logic    ready;
	logic    ok;
	target_t new_target;
	count_t  stop_count;

	modport source (output valid, output ok, output new_target, output stop_count,
		input ready);
	modport sink (input valid, input ok, input new_target, input stop_count,
		output ready);
endinterface
`default_nettype wire

[design/elevator_stop_table.sv]
// Sequence: an accepted request scans every slot (one read per slot through the
// shared comparator), then drains, then commits its result once the output is
// not stalled; the next request is taken only after its predecessor's result
// is registered, so requests never overlap.
// Reset: arst_n clears all slot valid bits, the stop count and the sequencer;
// the floor memory is not cleared, unwritten slots are never used.
`default_nettype none
module elevator_stop_table import est_pkg::*; #(
	parameter int CAPACITY   = 16,
	parameter int FLOOR_BITS = 6
) (
	input  wire logic clk,
	input  wire logic arst_n,
	est_req_if.sink   req,
	est_rsp_if.source rsp
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int FB    = FLOOR_BITS;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]          state_q;
	logic [IDX_W-1:0]    idx_q;
	op_t                 op_q;
	dir_t                dir_q;
	logic [FB-1:0]       floor_q;
	logic [FB-1:0]       cur_q;

	logic [FB-1:0]       floor_mem [CAPACITY];
	logic [FB-1:0]       rd_s1;
	logic                cmp_vld_s1;
	logic                slot_vld_s1;
	logic [IDX_W-1:0]    cmp_idx_s1;

	logic [CAPACITY-1:0] valid_q;
	logic [CNT_W-1:0]    cnt_q;

	logic                hit_q;
	logic [IDX_W-1:0]    hit_idx_q;
	logic                free_q;
	logic [IDX_W-1:0]    free_idx_q;
	logic                any_q;
	logic [FB-1:0]       ext_q;

	logic                rsp_vld_q;
	logic                ok_q;
	target_t             tgt_q;
	count_t              count_q;

	logic [FB-1:0]       cmp_a;
	logic [FB-1:0]       cmp_b;
	logic                cmp_eq;
	logic                cmp_gt;
	logic                take;

	logic                accept;
	logic                commit;
	logic                ok_d;
	logic [FB-1:0]       tgt_d;
	logic                wr_en;
	logic                clr_en;
	logic [CNT_W-1:0]    cnt_d;

	logic [FB+FLOOR_W-1:0]     floor_wide;
	logic [FB+FLOOR_W-1:0]     cur_wide;
	logic [FB+TARGET_W-1:0]    tgt_wide;
	logic [CNT_W+COUNT_W-1:0]  cnt_wide;

	assign floor_wide = {{FB{1'b0}}, req.floor};
	assign cur_wide   = {{FB{1'b0}}, req.current_target};
	assign tgt_wide   = {{TARGET_W{1'b0}}, tgt_d};
	assign cnt_wide   = {{COUNT_W{1'b0}}, cnt_d};

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign commit    = (state_q == ST_DONE) && (!rsp_vld_q || rsp.ready);

	assign rsp.valid      = rsp_vld_q;
	assign rsp.ok         = ok_q;
	assign rsp.new_target = tgt_q;
	assign rsp.stop_count = count_q;

	// Shared comparator: slot vs key (vs running extreme for target) during the scan, extreme vs target at commit.
	always_comb begin
		if (state_q == ST_DONE) begin
			cmp_a = ext_q;
			cmp_b = cur_q;
		end else begin
			cmp_a = rd_s1;
			cmp_b = (op_q == OP_TARGET) ? ext_q : floor_q;
		end
	end

	assign cmp_eq = (cmp_a == cmp_b);
	assign cmp_gt = (cmp_a > cmp_b);
	// Up wants the highest floor, anything else tracks the lowest.
	assign take   = (dir_q == DIR_UP) ? cmp_gt : (!cmp_gt && !cmp_eq);

	always_comb begin
		ok_d   = 1'b0;
		tgt_d  = cur_q;
		wr_en  = 1'b0;
		clr_en = 1'b0;
		cnt_d  = cnt_q;
		unique case (op_q)
			OP_ADD: begin
				if (cnt_q != FULL_CNT) begin
					ok_d = 1'b1;
					if (!hit_q) begin
						wr_en = 1'b1;
						cnt_d = cnt_q + CNT_W'(1);
					end
				end
			end
			OP_DELETE: begin
				if (cnt_q != '0 && hit_q) begin
					ok_d   = 1'b1;
					clr_en = 1'b1;
					cnt_d  = cnt_q - CNT_W'(1);
				end
			end
			OP_SEARCH: begin
				ok_d = hit_q;
			end
			OP_TARGET: begin
				if (any_q && dir_q == DIR_UP && cmp_gt) begin
					tgt_d = ext_q;
				end else if (any_q && dir_q == DIR_DOWN && !cmp_gt && !cmp_eq) begin
					tgt_d = ext_q;
				end
			end
			default: begin
				ok_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			idx_q      <= '0;
			cmp_vld_s1 <= 1'b0;
			valid_q    <= '0;
			cnt_q      <= '0;
			rsp_vld_q  <= 1'b0;
		end else begin
			cmp_vld_s1 <= (state_q == ST_SCAN);
			if (commit) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp_vld_q && rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (idx_q == LAST_IDX) begin
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (commit) begin
						cnt_q <= cnt_d;
						if (wr_en) begin
							valid_q[free_idx_q] <= 1'b1;
						end
						if (clr_en) begin
							valid_q[hit_idx_q] <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Scan trackers, request fields, slot read pipeline and result registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= req.op;
			dir_q   <= req.direction;
			floor_q <= floor_wide[FB-1:0];
			cur_q   <= cur_wide[FB-1:0];
			hit_q   <= 1'b0;
			free_q  <= 1'b0;
			any_q   <= 1'b0;
		end else if (cmp_vld_s1) begin
			if (slot_vld_s1 && cmp_eq && !hit_q) begin
				hit_q     <= 1'b1;
				hit_idx_q <= cmp_idx_s1;
			end
			if (!slot_vld_s1 && !free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= cmp_idx_s1;
			end
			if (slot_vld_s1 && (!any_q || take)) begin
				any_q <= 1'b1;
				ext_q <= rd_s1;
			end
		end
		slot_vld_s1 <= valid_q[idx_q];
		cmp_idx_s1  <= idx_q;
		if (commit) begin
			ok_q    <= ok_d;
			tgt_q   <= tgt_wide[TARGET_W-1:0];
			count_q <= cnt_wide[COUNT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (commit && wr_en) begin
			floor_mem[free_idx_q] <= floor_q;
		end
		rd_s1 <= floor_mem[idx_q];
	end

endmodule
`default_nettype wire

[design/est_chk.sv]
`default_nettype none
module est_chk import est_pkg::*; (
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    req_valid,
	input wire logic    req_ready,
	input wire logic    rsp_valid,
	input wire logic    rsp_ready,
	input wire logic    rsp_ok,
	input wire target_t rsp_new_target,
	input wire count_t  rsp_stop_count
);

	// A taken request drops the input ready.
	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("input ready right after a request was taken");

	// Returning to ready means a result has just been registered.
	a_result_on_release: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(req_ready) |-> rsp_valid)
		else $error("input released without a result");

	// Hold a stalled result.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok) &&
			$stable(rsp_new_target) && $stable(rsp_stop_count))
		else $error("stalled result changed");

endmodule

bind elevator_stop_table est_chk u_est_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_ok         (rsp.ok),
	.rsp_new_target (rsp.new_target),
	.rsp_stop_count (rsp.stop_count)
);
`default_nettype wire
